// File: rtl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the escape-time unit
// field widths, register indexes, controller states and the command and
// status groups between controller and datapath
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int COORD_W     = 12;
  localparam int LIMIT_W     = 16;
  localparam int VAL_W       = 64;
  localparam int STEP_W      = 63;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int WIDE_W      = 2 * VAL_W;

  localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CORNER_RE  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_CORNER_IM  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_STEP = CFG_INDEX_W'(3);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

  typedef struct packed {
    logic [LIMIT_W-1:0] iteration_limit;
    logic [VAL_W-1:0]   corner_real;
    logic [VAL_W-1:0]   corner_imag;
    logic [STEP_W-1:0]  pixel_step;
  } met_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMUL,
    S_CADD,
    S_MAG,
    S_MUL,
    S_SUM,
    S_TEST,
    S_DONE
  } met_state_t;

  typedef struct packed {
    logic load_pixel;
    logic mul_c;
    logic add_c;
    logic mag;
    logic mul;
    logic sum;
    logic update;
    logic set_result;
    logic result_escaped;
    logic load_out;
  } met_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic c_outside;
    logic escape;
    logic last_iter;
  } met_status_t;

endpackage

// File: rtl/met_ifs.sv
// ----------------------------------------------------------------------------
// met channel interfaces
// pixel request, result request and configuration write channels
// ----------------------------------------------------------------------------
interface met_pixel_if import met_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink (input valid, column, row, output ready);
endinterface

interface met_result_if import met_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               escaped;
  logic [LIMIT_W-1:0] escape_step;

  modport source (output valid, escaped, escape_step, input ready);
  modport sink (input valid, escaped, escape_step, output ready);
endinterface

interface met_cfg_if import met_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/met_cfg_regs.sv
// ----------------------------------------------------------------------------
// met_cfg_regs: configuration register file
// always ready; writes to unknown indexes are dropped
// ----------------------------------------------------------------------------
module met_cfg_regs import met_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  met_cfg_if.sink  cfg,
  output met_cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.iteration_limit <= LIMIT_RESET;
      regs.corner_real     <= '0;
      regs.corner_imag     <= '0;
      regs.pixel_step      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ITER_LIMIT: regs.iteration_limit <= cfg.data[LIMIT_W-1:0];
        REG_CORNER_RE:  regs.corner_real     <= cfg.data[VAL_W-1:0];
        REG_CORNER_IM:  regs.corner_imag     <= cfg.data[VAL_W-1:0];
        REG_PIXEL_STEP: regs.pixel_step      <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/met_datapath.sv
// ----------------------------------------------------------------------------
// met_datapath: fixed-point datapath of the escape-time unit
// forms c, then per iteration magnitudes, 32x32 partial products, wide
// squares and cross product, escape test and z update
// ----------------------------------------------------------------------------
module met_datapath import met_pkg::*; #(
  parameter int FRAC_BITS = 59,
  parameter int MAX_DIM   = 4096
) (
  input  logic               clk,
  input  met_cmd_t           cmd,
  input  met_cfg_t           regs,
  input  logic [COORD_W-1:0] column,
  input  logic [COORD_W-1:0] row,
  output met_status_t        status,
  output logic               escaped,
  output logic [LIMIT_W-1:0] escape_step
);

  localparam int DIM_CAP = (MAX_DIM > (1 << COORD_W)) ? (1 << COORD_W) : MAX_DIM;
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(DIM_CAP - 1);
  localparam int PROD_W = STEP_W + COORD_W;
  localparam int C_W    = PROD_W + 2;
  localparam logic signed [C_W-1:0] C_BOUND =
    {{(C_W-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
  localparam logic [WIDE_W:0] FOUR = {{WIDE_W{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  logic [COORD_W-1:0] col_q, row_q;
  logic [PROD_W-1:0]  prod_re, prod_im;
  logic [VAL_W-1:0]   x, y, cre, cim;
  logic               c_outside;
  logic [VAL_W-1:0]   ax, ay;
  logic               neg_xy;
  logic [VAL_W-1:0]   xx_ll, xx_lh, xx_hh, yy_ll, yy_lh, yy_hh;
  logic [VAL_W-1:0]   xy_ll, xy_lh, xy_hl, xy_hh;
  logic [WIDE_W-1:0]  xx, yy, xy;
  logic [LIMIT_W-1:0] count;
  logic               res_escaped;
  logic [LIMIT_W-1:0] res_step;

  logic signed [C_W-1:0]    sum_re, sum_im;
  logic [WIDE_W:0]          mag2;
  logic signed [WIDE_W-1:0] re_diff, re_sh, xy_s, im_sh;
  logic [VAL_W-1:0]         x_next, y_next;

  // c from the corner and the pixel offset, full width
  assign sum_re = $signed({{(C_W-VAL_W){regs.corner_real[VAL_W-1]}}, regs.corner_real})
                + $signed({2'b00, prod_re});
  assign sum_im = $signed({{(C_W-VAL_W){regs.corner_imag[VAL_W-1]}}, regs.corner_imag})
                - $signed({2'b00, prod_im});

  // escape test and next z
  assign mag2    = {1'b0, xx} + {1'b0, yy};
  assign re_diff = $signed(xx - yy);
  assign re_sh   = re_diff >>> FRAC_BITS;
  assign x_next  = re_sh[VAL_W-1:0] + cre;
  assign xy_s    = neg_xy ? -$signed(xy) : $signed(xy);
  assign im_sh   = xy_s >>> (FRAC_BITS - 1);
  assign y_next  = im_sh[VAL_W-1:0] + cim;

  always_comb begin
    status.limit_zero = (regs.iteration_limit == '0);
    status.c_outside  = c_outside;
    status.escape     = (mag2 > FOUR);
    status.last_iter  = (({1'b0, count} + (LIMIT_W+1)'(1)) == {1'b0, regs.iteration_limit});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      col_q <= (column > COORD_MAX) ? COORD_MAX : column;
      row_q <= (row > COORD_MAX) ? COORD_MAX : row;
      count <= '0;
    end
    if (cmd.mul_c) begin
      prod_re <= PROD_W'(regs.pixel_step) * PROD_W'(col_q);
      prod_im <= PROD_W'(regs.pixel_step) * PROD_W'(row_q);
    end
    if (cmd.add_c) begin
      cre       <= sum_re[VAL_W-1:0];
      cim       <= sum_im[VAL_W-1:0];
      x         <= sum_re[VAL_W-1:0];
      y         <= sum_im[VAL_W-1:0];
      c_outside <= (sum_re > C_BOUND) || (sum_re < -C_BOUND) ||
                   (sum_im > C_BOUND) || (sum_im < -C_BOUND);
    end
    if (cmd.mag) begin
      ax     <= x[VAL_W-1] ? (~x + VAL_W'(1)) : x;
      ay     <= y[VAL_W-1] ? (~y + VAL_W'(1)) : y;
      neg_xy <= x[VAL_W-1] ^ y[VAL_W-1];
    end
    if (cmd.mul) begin
      xx_ll <= VAL_W'(ax[31:0]) * VAL_W'(ax[31:0]);
      xx_lh <= VAL_W'(ax[31:0]) * VAL_W'(ax[63:32]);
      xx_hh <= VAL_W'(ax[63:32]) * VAL_W'(ax[63:32]);
      yy_ll <= VAL_W'(ay[31:0]) * VAL_W'(ay[31:0]);
      yy_lh <= VAL_W'(ay[31:0]) * VAL_W'(ay[63:32]);
      yy_hh <= VAL_W'(ay[63:32]) * VAL_W'(ay[63:32]);
      xy_ll <= VAL_W'(ax[31:0]) * VAL_W'(ay[31:0]);
      xy_lh <= VAL_W'(ax[31:0]) * VAL_W'(ay[63:32]);
      xy_hl <= VAL_W'(ax[63:32]) * VAL_W'(ay[31:0]);
      xy_hh <= VAL_W'(ax[63:32]) * VAL_W'(ay[63:32]);
    end
    if (cmd.sum) begin
      xx <= {xx_hh, xx_ll} + {31'b0, xx_lh, 33'b0};
      yy <= {yy_hh, yy_ll} + {31'b0, yy_lh, 33'b0};
      xy <= {xy_hh, xy_ll} + {32'b0, xy_lh, 32'b0} + {32'b0, xy_hl, 32'b0};
    end
    if (cmd.update) begin
      x     <= x_next;
      y     <= y_next;
      count <= count + LIMIT_W'(1);
    end
    if (cmd.set_result) begin
      res_escaped <= cmd.result_escaped;
      res_step    <= cmd.result_escaped ? count : '0;
    end
    if (cmd.load_out) begin
      escaped     <= res_escaped;
      escape_step <= res_step;
    end
  end

endmodule

// File: rtl/met_ctrl.sv
// ----------------------------------------------------------------------------
// met_ctrl: sequencer of the escape-time unit
// steps the datapath through c set-up and the iteration loop,
// owns the result valid flag
// ----------------------------------------------------------------------------
module met_ctrl import met_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  met_status_t status,
  output met_cmd_t    cmd
);

  met_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pixel_valid) begin
          state_next = status.limit_zero ? S_DONE : S_CMUL;
        end
      end
      S_CMUL: state_next = S_CADD;
      S_CADD: state_next = S_MAG;
      S_MAG:  state_next = status.c_outside ? S_DONE : S_MUL;
      S_MUL:  state_next = S_SUM;
      S_SUM:  state_next = S_TEST;
      S_TEST: begin
        if (status.escape || status.last_iter) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MAG;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    pixel_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.load_pixel = 1'b1;
          cmd.set_result = status.limit_zero;
        end
      end
      S_CMUL: cmd.mul_c = 1'b1;
      S_CADD: cmd.add_c = 1'b1;
      S_MAG: begin
        if (status.c_outside) begin
          cmd.set_result     = 1'b1;
          cmd.result_escaped = 1'b1;
        end else begin
          cmd.mag = 1'b1;
        end
      end
      S_MUL: cmd.mul = 1'b1;
      S_SUM: cmd.sum = 1'b1;
      S_TEST: begin
        priority if (status.escape) begin
          cmd.set_result     = 1'b1;
          cmd.result_escaped = 1'b1;
        end else if (status.last_iter) begin
          cmd.set_result = 1'b1;
        end else begin
          cmd.update = 1'b1;
        end
      end
      S_DONE: cmd.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending one");

  // one pixel in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready) |=> !pixel_ready)
    else $error("second pixel taken while busy");

  // datapath steps never overlap
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mul_c, cmd.add_c, cmd.mag, cmd.mul, cmd.sum, cmd.update}))
    else $error("overlapping datapath steps");

endmodule

// File: rtl/mandelbrot_escape_time_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit: escape-time iteration for one pixel
// per pixel: c set-up, then one iteration pass per escape test (1 to
//   iteration_limit); no pass when c lies beyond +-2, no set-up at zero limit
// throughput: one pixel at a time, set by the shared magnitude / partial
//   product / wide sum / test-and-update sequence; a result still waiting
//   holds the sequencer in its last state
// reset: limit back to 1000, corner and step to 0, sequencer idle, no result
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit import met_pkg::*; #(
  parameter int FRAC_BITS = 59,
  parameter int MAX_DIM   = 4096
) (
  input  logic          clk,
  input  logic          rst,
  met_pixel_if.sink     pixel,
  met_result_if.source  result,
  met_cfg_if.sink       cfg
);

  // configuration registers; the user writes them only while no pixel is in flight, the block does not enforce it
  met_cfg_t    regs;
  // command and status groups between sequencer and datapath
  met_cmd_t    cmd;
  met_status_t status;

  logic pixel_ready;
  logic out_valid;

  met_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // sequencer: idle accepts a pixel, then c set-up, then the iteration
  // loop, then the result is parked in the output register; the next
  // pixel request may be taken while that result still waits
  met_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel_ready),
    .out_valid   (out_valid),
    .out_ready   (result.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // datapath: ten 32x32 multipliers in parallel build the three 64x64
  // products, each registered before the wide sums
  met_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .regs        (regs),
    .column      (pixel.column),
    .row         (pixel.row),
    .status      (status),
    .escaped     (result.escaped),
    .escape_step (result.escape_step)
  );

  assign pixel.ready  = pixel_ready;
  assign result.valid = out_valid;

endmodule
